>>> sv/ucd_pkg.sv
package ucd_pkg;

	localparam int MAX_PAYLOAD = 8;
	localparam int HDR_LEN     = 4;
	localparam int BYTE_W      = 8;
	localparam int ID_W        = 11;
	localparam int LEN_W       = 4;
	localparam int PAYLOAD_W   = 64;
	// wide enough for the deepest buffer (header plus eight data bytes)
	localparam int OP_CNT_W    = 4;

	localparam logic [BYTE_W-1:0] MARKER_RESET = 8'hAA;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	typedef struct packed {
		logic                shift_en;
		logic [OP_CNT_W-1:0] shift_amt;
		logic                wr_en;
		logic [OP_CNT_W-1:0] wr_idx;
		logic [BYTE_W-1:0]   wr_data;
	} buf_op_t;

endpackage

>>> sv/ucd_buf.sv
module ucd_buf #(
	parameter int Depth = ucd_pkg::HDR_LEN + ucd_pkg::MAX_PAYLOAD
) (
	input  logic                                    clk,
	input  ucd_pkg::buf_op_t                        op,
	output logic [Depth-1:0][ucd_pkg::BYTE_W-1:0]   entries
);

	localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;

	logic [ucd_pkg::BYTE_W-1:0] mem_q [Depth];
	logic [ucd_pkg::BYTE_W-1:0] nxt   [Depth];

	// front-drop shifter, then single-entry write
	always_comb begin
		int src;
		for (int i = 0; i < Depth; i++) begin
			src = i + int'(op.shift_amt);
			nxt[i] = mem_q[i];
			if (op.shift_en && src < Depth) begin
				nxt[i] = mem_q[IdxW'(src)];
			end
			if (op.wr_en && op.wr_idx == (ucd_pkg::OP_CNT_W)'(i)) begin
				nxt[i] = op.wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < Depth; i++) begin
			mem_q[i] <= nxt[i];
		end
	end

	always_comb begin
		for (int i = 0; i < Depth; i++) begin
			entries[i] = mem_q[i];
		end
	end

endmodule

>>> sv/uart_can_frame_deframer_unit.sv
// Flow: a beat is accepted while idle; the scanner then drops bad leading bytes one at a
// time (at most 1 + MaxPayload per beat) and looks for a frame; a frame lands in the output
// register at the end of the cycle that finds it, or waits while the previous frame is unread.
// in_ready is high only while idle, so a new byte is not taken until the scan is done, and
// an unread output frame holds the scan. Reset: arst_n clears state, byte count, output
// valid; start marker returns to 0xAA. The byte buffer is not reset.
module uart_can_frame_deframer_unit #(
	parameter int MaxPayload = ucd_pkg::MAX_PAYLOAD
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [ucd_pkg::BYTE_W-1:0]     cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [ucd_pkg::BYTE_W-1:0]     rx_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ucd_pkg::ID_W-1:0]       frame_id,
	output logic [ucd_pkg::LEN_W-1:0]      frame_length,
	output logic [ucd_pkg::PAYLOAD_W-1:0]  frame_payload
);

	localparam int Depth = ucd_pkg::HDR_LEN + MaxPayload;
	localparam int CntW  = $clog2(Depth + 1);
	localparam int FlW   = ucd_pkg::BYTE_W + 1;

	ucd_pkg::state_t                      state_q;
	logic [CntW-1:0]                      count_q;
	logic [ucd_pkg::BYTE_W-1:0]           marker_q;
	logic                                 produced_q;
	logic                                 out_valid_q;
	logic [ucd_pkg::ID_W-1:0]             id_q;
	logic [ucd_pkg::LEN_W-1:0]            len_q;
	logic [ucd_pkg::PAYLOAD_W-1:0]        payload_q;

	logic [Depth-1:0][ucd_pkg::BYTE_W-1:0] entries;
	ucd_pkg::buf_op_t                     op;

	logic                                 full;
	logic                                 hdr_ok;
	logic                                 bad;
	logic [FlW-1:0]                       flen;
	logic                                 incomplete;
	logic                                 complete;
	logic                                 stall;
	logic                                 emit;
	logic [ucd_pkg::PAYLOAD_W-1:0]        payload_d;

	ucd_buf #(.Depth(Depth)) u_buf (
		.clk     (clk),
		.op      (op),
		.entries (entries)
	);

	assign full       = (count_q == CntW'(Depth));
	assign hdr_ok     = (count_q >= CntW'(ucd_pkg::HDR_LEN));
	assign bad        = (entries[0] != marker_q) ||
	                    (entries[3] > ucd_pkg::BYTE_W'(MaxPayload));
	assign flen       = FlW'(ucd_pkg::HDR_LEN) + FlW'(entries[3]);
	assign incomplete = (FlW'(count_q) < flen);
	assign complete   = (state_q == ucd_pkg::ST_SCAN) && hdr_ok && !bad && !incomplete;
	assign stall      = complete && !produced_q && out_valid_q && !out_ready;
	assign emit       = complete && !produced_q && !stall;

	assign in_ready      = (state_q == ucd_pkg::ST_IDLE);
	assign out_valid     = out_valid_q;
	assign frame_id      = id_q;
	assign frame_length  = len_q;
	assign frame_payload = payload_q;

	always_comb begin
		payload_d = '0;
		for (int k = 0; k < MaxPayload; k++) begin
			if (ucd_pkg::BYTE_W'(k) < entries[3]) begin
				payload_d[k*ucd_pkg::BYTE_W +: ucd_pkg::BYTE_W] = entries[ucd_pkg::HDR_LEN + k];
			end
		end
	end

	always_comb begin
		op = '0;
		unique case (state_q)
			ucd_pkg::ST_IDLE: begin
				if (in_valid) begin
					op.wr_en     = 1'b1;
					op.wr_data   = rx_byte;
					op.shift_en  = full;
					op.shift_amt = ucd_pkg::OP_CNT_W'(1);
					op.wr_idx    = full ? ucd_pkg::OP_CNT_W'(Depth - 1)
					                    : ucd_pkg::OP_CNT_W'(count_q);
				end
			end
			ucd_pkg::ST_SCAN: begin
				if (hdr_ok && bad) begin
					op.shift_en  = 1'b1;
					op.shift_amt = ucd_pkg::OP_CNT_W'(1);
				end else if (complete && !stall) begin
					op.shift_en  = 1'b1;
					op.shift_amt = ucd_pkg::OP_CNT_W'(flen);
				end
			end
			default: op = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ucd_pkg::ST_IDLE;
			count_q     <= '0;
			marker_q    <= ucd_pkg::MARKER_RESET;
			produced_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				marker_q <= cfg_wr_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end
			unique case (state_q)
				ucd_pkg::ST_IDLE: begin
					if (in_valid) begin
						if (!full) begin
							count_q <= count_q + CntW'(1);
						end
						produced_q <= 1'b0;
						state_q    <= ucd_pkg::ST_SCAN;
					end
				end
				ucd_pkg::ST_SCAN: begin
					priority if (!hdr_ok) begin
						state_q <= ucd_pkg::ST_IDLE;
					end else if (bad) begin
						count_q <= count_q - CntW'(1);
					end else if (incomplete) begin
						state_q <= ucd_pkg::ST_IDLE;
					end else if (stall) begin
						// output register busy
						count_q <= count_q;
					end else begin
						count_q    <= count_q - CntW'(flen);
						produced_q <= 1'b1;
					end
				end
				default: state_q <= ucd_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			id_q      <= {entries[1][ucd_pkg::ID_W-ucd_pkg::BYTE_W-1:0], entries[2]};
			len_q     <= entries[3][ucd_pkg::LEN_W-1:0];
			payload_q <= payload_d;
		end
	end

`ifndef SYNTHESIS
	a_idle_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ucd_pkg::ST_IDLE) |-> (count_q < CntW'(Depth)))
		else $error("buffer full while idle");

	a_emit_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ucd_pkg::ST_SCAN))
		else $error("frame raised outside scan");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (len_q <= ucd_pkg::LEN_W'(MaxPayload)))
		else $error("frame length out of range");

	a_one_per_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && state_q == ucd_pkg::ST_SCAN) |=> !emit)
		else $error("second frame from one byte");
`endif

endmodule

>>> tb/uart_can_frame_deframer_checker.sv
`timescale 1ns / 1ps
module uart_can_frame_deframer_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [ucd_pkg::BYTE_W-1:0]     cfg_wr_data,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [ucd_pkg::BYTE_W-1:0]     rx_byte,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [ucd_pkg::ID_W-1:0]       frame_id,
	input  logic [ucd_pkg::LEN_W-1:0]      frame_length,
	input  logic [ucd_pkg::PAYLOAD_W-1:0]  frame_payload,
	output int unsigned                    mismatch_count,
	output int unsigned                    due_count
);
	import ucd_pkg::*;

	localparam int BUF_DEPTH = HDR_LEN + MAX_PAYLOAD;

	typedef struct packed {
		logic [ID_W-1:0]      id;
		logic [LEN_W-1:0]     len;
		logic [PAYLOAD_W-1:0] payload;
	} can_frame_t;

	logic [BYTE_W-1:0] marker;
	logic [BYTE_W-1:0] held_bytes [BUF_DEPTH];
	int unsigned       held_cnt;
	int unsigned       fails;
	can_frame_t        frames_due [$];
	can_frame_t        oldest;

	function automatic void shift_out(int unsigned n);
		int unsigned i;
		if (n >= held_cnt) begin
			held_cnt = 0;
		end else begin
			for (i = 0; i + n < held_cnt; i++)
				held_bytes[i] = held_bytes[i + n];
			held_cnt -= n;
		end
	endfunction

	function automatic void deframe_byte(logic [BYTE_W-1:0] b);
		int unsigned dlc;
		int unsigned k;
		bit          scanning;
		bit          found;
		logic [15:0] raw_id;
		can_frame_t  f;
		found = 1'b0;
		scanning = 1'b1;
		if (held_cnt >= BUF_DEPTH)
			shift_out(1);
		held_bytes[held_cnt] = b;
		held_cnt++;
		while (scanning && held_cnt >= HDR_LEN) begin
			dlc = 32'(held_bytes[3]);
			if (held_bytes[0] != marker || dlc > MAX_PAYLOAD) begin
				shift_out(1);
			end else if (held_cnt < HDR_LEN + dlc) begin
				scanning = 1'b0;
			end else begin
				if (!found) begin
					raw_id = {held_bytes[1], held_bytes[2]};
					f.id = raw_id[ID_W-1:0];
					f.len = dlc[LEN_W-1:0];
					f.payload = '0;
					for (k = 0; k < dlc; k++)
						f.payload[8*k +: 8] = held_bytes[HDR_LEN + k];
					frames_due.push_back(f);
					found = 1'b1;
				end
				shift_out(HDR_LEN + dlc);
			end
		end
	endfunction

	task automatic report(string msg);
		$display("%0t ns: %s", $time, msg);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker = MARKER_RESET;
			held_cnt = 0;
			fails = 0;
			frames_due.delete();
			mismatch_count <= 0;
			due_count <= 0;
		end else begin
			if (cfg_wr_en)
				marker = cfg_wr_data;
			if (in_valid && in_ready)
				deframe_byte(rx_byte);
			if (out_valid && out_ready) begin
				if (frames_due.size() == 0) begin
					report($sformatf("frame id %h len %0d with nothing due", frame_id,
						frame_length));
				end else begin
					oldest = frames_due.pop_front();
					if (frame_id !== oldest.id)
						report($sformatf("frame_id %h, want %h", frame_id, oldest.id));
					if (frame_length !== oldest.len)
						report($sformatf("frame_length %0d, want %0d", frame_length,
							oldest.len));
					if (frame_payload !== oldest.payload)
						report($sformatf("frame_payload %h, want %h", frame_payload,
							oldest.payload));
				end
			end
			mismatch_count <= fails;
			due_count <= frames_due.size();
		end
	end

endmodule

>>> tb/uart_can_frame_deframer_unit_tb.sv
`timescale 1ns / 1ps
module uart_can_frame_deframer_unit_tb;
	import ucd_pkg::*;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_BYTES   = 300;

	typedef enum int {
		RX_FREE,
		RX_PATTERN,
		RX_RANDOM
	} rx_mode_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [BYTE_W-1:0]    cfg_wr_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [BYTE_W-1:0]    rx_byte = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [ID_W-1:0]      frame_id;
	logic [LEN_W-1:0]     frame_length;
	logic [PAYLOAD_W-1:0] frame_payload;
	int unsigned          mismatch_count;
	int unsigned          due_count;

	logic [BYTE_W-1:0] tx_q [$];
	int unsigned       bytes_queued;
	int unsigned       burst_left;
	int unsigned       gap_left;
	rx_mode_t          rx_mode;
	int unsigned       mode_left;
	logic [15:0]       stall_pat;
	logic [BYTE_W-1:0] marker;
	int unsigned       cycle_cnt;

	uart_can_frame_deframer_unit i_dut (.*);

	uart_can_frame_deframer_checker i_checker (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// sender: bursts of beats with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else if (!in_valid || in_ready) begin
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (tx_q.size() != 0) begin
				in_valid <= 1'b1;
				rx_byte <= tx_q.pop_front();
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 48);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: switches at random between free, pattern and random stall modes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_mode = RX_FREE;
			mode_left = 0;
			stall_pat = '1;
		end else begin
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(16, 200);
				stall_pat = 16'($urandom);
				stall_pat[0] = 1'b1;
			end else begin
				mode_left--;
			end
			stall_pat = {stall_pat[14:0], stall_pat[15]};
			case (rx_mode)
				RX_FREE:    out_ready <= 1'b1;
				RX_PATTERN: out_ready <= stall_pat[0];
				default:    out_ready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	function automatic void push_byte(logic [BYTE_W-1:0] b);
		tx_q.push_back(b);
		bytes_queued++;
	endfunction

	function automatic void queue_frame(logic [15:0] id, int unsigned dlc,
			logic [PAYLOAD_W-1:0] data);
		int unsigned k;
		push_byte(marker);
		push_byte(id[15:8]);
		push_byte(id[7:0]);
		push_byte(dlc[BYTE_W-1:0]);
		for (k = 0; k < dlc && k < MAX_PAYLOAD; k++)
			push_byte(data[8*k +: 8]);
	endfunction

	function automatic void queue_random_traffic(int unsigned n_bytes);
		int unsigned target;
		int unsigned pick;
		int unsigned dlc;
		int unsigned n;
		target = bytes_queued + n_bytes;
		while (bytes_queued < target) begin
			pick = $urandom_range(0, 19);
			if (pick < 14) begin
				case ($urandom_range(0, 9))
					0:       dlc = 0;
					1:       dlc = MAX_PAYLOAD;
					default: dlc = $urandom_range(0, MAX_PAYLOAD);
				endcase
				queue_frame(16'($urandom), dlc, {$urandom, $urandom});
			end else if (pick < 16) begin
				// line noise
				repeat ($urandom_range(1, 6))
					push_byte(BYTE_W'($urandom));
			end else if (pick < 18) begin
				// length byte out of range
				push_byte(marker);
				push_byte(BYTE_W'($urandom));
				push_byte(BYTE_W'($urandom));
				push_byte(BYTE_W'($urandom_range(MAX_PAYLOAD + 1, 255)));
			end else begin
				// frame cut short, later bytes fill it
				dlc = $urandom_range(1, MAX_PAYLOAD);
				push_byte(marker);
				push_byte(BYTE_W'($urandom));
				push_byte(BYTE_W'($urandom));
				push_byte(dlc[BYTE_W-1:0]);
				n = $urandom_range(0, dlc - 1);
				repeat (n)
					push_byte(BYTE_W'($urandom));
			end
		end
	endfunction

	task automatic write_marker(logic [BYTE_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		marker = value;
	endtask

	// wait until all bytes are sent, all frames are out and the scanner has settled
	task automatic drain();
		do
			@(negedge clk);
		while (tx_q.size() != 0 || in_valid || !in_ready || out_valid || due_count != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("uart_can_frame_deframer_unit_tb: FAIL");
		$finish;
	end

	initial begin
		logic [BYTE_W-1:0] phase_marker [6];
		int unsigned p;
		bytes_queued = 0;
		marker = MARKER_RESET;
		phase_marker[0] = 8'h00;
		phase_marker[1] = 8'hFF;
		phase_marker[2] = BYTE_W'($urandom);
		phase_marker[3] = BYTE_W'($urandom);
		phase_marker[4] = MARKER_RESET;
		phase_marker[5] = BYTE_W'($urandom);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// empty frame with all ID bits set
		queue_frame(16'hFFFF, 0, '0);
		// stray byte ahead of a full frame
		push_byte(8'h55);
		queue_frame(16'h0000, MAX_PAYLOAD, '1);
		// length just past the limit, then the largest length byte
		queue_frame(16'h1234, MAX_PAYLOAD + 1, '0);
		queue_frame(16'h0102, 255, '0);
		drain();

		for (p = 0; p < 6; p++) begin
			write_marker(phase_marker[p]);
			queue_random_traffic(PHASE_BYTES);
			drain();
		end

		if (mismatch_count == 0 && due_count == 0)
			$display("uart_can_frame_deframer_unit_tb: PASS");
		else
			$display("uart_can_frame_deframer_unit_tb: FAIL");
		$finish;
	end

endmodule

>>> filelist.f
sv/ucd_pkg.sv
sv/ucd_buf.sv
sv/uart_can_frame_deframer_unit.sv
tb/uart_can_frame_deframer_checker.sv
tb/uart_can_frame_deframer_unit_tb.sv
